### rtl/core/pftd_pkg.sv
// Package for the trial division prime filter.
// Holds the default width, the controller states and the command and status bundles.
// No dependencies.
package pftd_pkg;

	localparam int VALUE_WIDTH_DEF = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_TEST,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step_d;
		logic div_start;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic lt_two;
		logic sq_gt_n;
		logic div_last;
		logic rem_zero;
	} status_t;

endpackage

### rtl/core/prime_filter_trial_division_core.sv
// Prime filter by trial division: passes on only the prime input values.
// A value below two is dropped; for any other item each trial divisor is tried in turn,
// the divisors being 2, 3, then odd values up to the square root.
// A prime may then wait on the output. One item is in work at a time.
// Reset (arst_n, asynchronous) clears the controller state and the output valid flag.
// Depends on pftd_pkg, pftd_ctrl and pftd_datapath.
module prime_filter_trial_division_core #(
	parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,  // value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_tdata   // prime_value
);

	localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

	pftd_pkg::cmd_t           cmd;
	pftd_pkg::status_t        status;
	logic [VALUE_WIDTH-1:0]   prime_value;

	pftd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pftd_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.value       (s_tdata[VALUE_WIDTH-1:0]),
		.cmd         (cmd),
		.status      (status),
		.prime_value (prime_value)
	);

	assign m_tdata = TDATA_W'(prime_value);

endmodule

### rtl/core/pftd_datapath.sv
// Datapath of the prime filter: value and divisor registers, square tracker,
// bit-serial remainder unit and the output register.
// Depends on pftd_pkg.
module pftd_datapath #(
	parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic [VALUE_WIDTH-1:0] value,
	input  pftd_pkg::cmd_t         cmd,
	output pftd_pkg::status_t      status,
	output logic [VALUE_WIDTH-1:0] prime_value
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W);

	logic [W-1:0]  n_q;
	logic [W-1:0]  d_q;
	logic [W+1:0]  sq_q;
	logic [W-1:0]  sh_q;
	logic [W-1:0]  r_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  out_q;

	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          d_is_two;

	assign trial    = {r_q, sh_q[W-1]};
	assign diff     = trial - {1'b0, d_q};
	assign d_is_two = (d_q == W'(2));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= value;
			d_q  <= W'(2);
			sq_q <= (W+2)'(4);
		end else if (cmd.step_d) begin
			if (d_is_two) begin
				d_q  <= W'(3);
				sq_q <= (W+2)'(9);
			end else begin
				d_q  <= d_q + W'(2);
				sq_q <= sq_q + {d_q, 2'b00} + (W+2)'(4);
			end
		end
		if (cmd.div_start) begin
			sh_q  <= n_q;
			r_q   <= '0;
			cnt_q <= CW'(W-1);
		end else if (cmd.div_step) begin
			sh_q  <= {sh_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
			if (!diff[W]) begin
				r_q <= diff[W-1:0];
			end else begin
				r_q <= trial[W-1:0];
			end
		end
		if (cmd.emit) begin
			out_q <= n_q;
		end
	end

	assign status.lt_two   = (n_q < W'(2));
	assign status.sq_gt_n  = (sq_q > {2'b00, n_q});
	assign status.div_last = (cnt_q == '0);
	assign status.rem_zero = (r_q == '0);
	assign prime_value     = out_q;

endmodule

### rtl/core/pftd_ctrl.sv
// Controller of the prime filter: sequences load, divisor steps and the
// remainder iterations, and owns both handshakes.
// Depends on pftd_pkg.
module pftd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  pftd_pkg::status_t status,
	output pftd_pkg::cmd_t    cmd
);

	pftd_pkg::state_t state_q;
	pftd_pkg::state_t state_next;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pftd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		unique case (state_q)
			pftd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load   = 1'b1;
					state_next = pftd_pkg::ST_CHECK;
				end
			end
			pftd_pkg::ST_CHECK: begin
				if (status.lt_two) begin
					state_next = pftd_pkg::ST_IDLE;
				end else if (status.sq_gt_n) begin
					state_next = pftd_pkg::ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_next    = pftd_pkg::ST_DIV;
				end
			end
			pftd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_next = pftd_pkg::ST_TEST;
				end
			end
			pftd_pkg::ST_TEST: begin
				if (status.rem_zero) begin
					state_next = pftd_pkg::ST_IDLE;
				end else begin
					cmd.step_d = 1'b1;
					state_next = pftd_pkg::ST_CHECK;
				end
			end
			pftd_pkg::ST_EMIT: begin
				if (out_free) begin
					cmd.emit   = 1'b1;
					state_next = pftd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = pftd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### test/pftd_checker.sv
// Scoreboard for the trial division prime filter: watches both stream channels,
// works out which accepted items are prime and compares the emitted items in order.
// Depends on pftd_pkg for the default value width.
`timescale 1ns / 1ps

module pftd_checker #(
	parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,  // value
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata,  // prime_value
	output int                               fail_count,
	output int                               pending_primes
);

	logic [VALUE_WIDTH-1:0] expected_primes [$];
	logic [VALUE_WIDTH-1:0] oldest_prime;
	logic [VALUE_WIDTH-1:0] candidate;

	initial begin
		fail_count = 0;
		pending_primes = 0;
	end

	function automatic bit prime_by_trial(input longint unsigned n);
		longint unsigned d;
		if (n < 2)
			return 1'b0;
		if (n < 4)
			return 1'b1;
		if ((n % 2) == 0 || (n % 3) == 0)
			return 1'b0;
		for (d = 5; d <= n / d; d += 6) begin
			if ((n % d) == 0 || (n % (d + 2)) == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_primes.size() == 0) begin
					report_mismatch($sformatf("output item 0x%h with no prime waiting", m_tdata));
				end else begin
					oldest_prime = expected_primes.pop_front();
					if (m_tdata[VALUE_WIDTH-1:0] !== oldest_prime)
						report_mismatch($sformatf("prime_value %0d, expected %0d",
							m_tdata[VALUE_WIDTH-1:0], oldest_prime));
					if ((m_tdata >> VALUE_WIDTH) !== '0)
						report_mismatch($sformatf("padding bits of output item 0x%h not zero",
							m_tdata));
				end
			end
			if (s_tvalid && s_tready) begin
				candidate = s_tdata[VALUE_WIDTH-1:0];
				if (prime_by_trial(candidate))
					expected_primes.push_back(candidate);
			end
			pending_primes <= expected_primes.size();
		end
	end

endmodule

### test/tb_top.sv
// Top of the prime filter testbench: clock, reset, input items and output stalls
// in four idling phases, and the final verdict. Depends on pftd_pkg, the core
// prime_filter_trial_division_core and the pftd_checker scoreboard.
`timescale 1ns / 1ps

module tb_top;

	localparam int VW    = pftd_pkg::VALUE_WIDTH_DEF;
	localparam int BUS_W = ((VW + 7) / 8) * 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [BUS_W-1:0] s_tdata = '0;  // value
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [BUS_W-1:0] m_tdata;       // prime_value

	int fail_count;
	int pending_primes;
	int gap_pct = 0;
	int stall_pct = 0;

	int unsigned directed_words [] = '{
		0, 1, 2, 3, 4, 5, 9, 25, 35, 49, 121, 169, 289, 323, 7919, 65521, 65535,
		32'd1073741824, 32'd2147483643, 32'd2147483645, 32'd2147483646, 32'd2147483647,
		32'h8000_0000, 32'h8000_0002, 32'h8000_0007
	};
	int gap_by_phase   [4] = '{0, 74, 0, 20};
	int stall_by_phase [4] = '{0, 0, 74, 20};

	prime_filter_trial_division_core #(.VALUE_WIDTH(VW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pftd_checker #(.VALUE_WIDTH(VW)) checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.fail_count     (fail_count),
		.pending_primes (pending_primes)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Large odd values can need trial divisors up to their square root, so
	// full-width values are built as multiples of a small prime.
	function automatic logic [BUS_W-1:0] draw_value();
		int unsigned      small_primes [6] = '{2, 3, 5, 7, 11, 13};
		int unsigned      tier;
		int unsigned      factor;
		longint unsigned  v;
		logic [BUS_W-1:0] pad;
		tier = $urandom_range(99);
		if (tier < 50) begin
			v = $urandom_range(1023);
		end else if (tier < 82) begin
			v = $urandom_range(16383);
		end else begin
			factor = small_primes[$urandom_range(5)];
			v = longint'($urandom_range(((64'd1 << VW) - 1) / factor)) * factor;
		end
		pad = $urandom();
		return (pad << VW) | BUS_W'(v);
	endfunction

	task automatic push_value(input logic [BUS_W-1:0] word);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	initial begin
		#100_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_words[i])
			push_value(BUS_W'(directed_words[i]));
		for (int phase = 0; phase < 4; phase++) begin
			gap_pct   = gap_by_phase[phase];
			stall_pct = stall_by_phase[phase];
			repeat (100)
				push_value(draw_value());
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_primes != 0)
			@(posedge clk);
		repeat (4000) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
rtl/core/pftd_pkg.sv
rtl/core/pftd_datapath.sv
rtl/core/pftd_ctrl.sv
rtl/core/prime_filter_trial_division_core.sv
test/pftd_checker.sv
test/tb_top.sv
